// ----- hw/rtl/directed_graph_reachability_core_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the directed graph reachability core
// Shared helpers for concurrent checks clocked on clk and gated by rst.
// ----------------------------------------------------------------------------
`ifndef DIRECTED_GRAPH_REACHABILITY_CORE_DEFINES_SVH
`define DIRECTED_GRAPH_REACHABILITY_CORE_DEFINES_SVH

// Same-cycle implication check.
`define DGR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dgr check failed: same-cycle implication");

// Next-cycle implication check.
`define DGR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dgr check failed: next-cycle implication");

`endif

// ----- hw/rtl/dgr_pkg.sv -----
// ----------------------------------------------------------------------------
// Directed graph reachability package
// Sizes, operation codes and sequencer states shared by the core files.
// ----------------------------------------------------------------------------
package dgr_pkg;

  // Number of graph nodes and the index width that addresses them.
  localparam int NODES  = 64;
  localparam int NODE_W = $clog2(NODES);

  // Widths of the item fields.
  localparam int OP_W   = 2;
  localparam int FIELD_W = 6;

  // Operation codes carried by an input item.
  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EDGE,
    ST_QUERY,
    ST_RESP
  } state_t;

endpackage

// ----- hw/rtl/dgr_channels.sv -----
// ----------------------------------------------------------------------------
// Directed graph reachability channels
// Valid/ready channels for the request items and the result items.
// ----------------------------------------------------------------------------
interface dgr_req_if;
  logic                        valid;
  logic                        ready;
  logic [dgr_pkg::OP_W-1:0]    operation;
  logic [dgr_pkg::FIELD_W-1:0] src_node;
  logic [dgr_pkg::FIELD_W-1:0] dst_node;

  modport source (output valid, output operation, output src_node, output dst_node,
                  input ready);
  modport sink (input valid, input operation, input src_node, input dst_node,
                output ready);
endinterface

interface dgr_rsp_if;
  logic valid;
  logic ready;
  logic success;

  modport source (output valid, output success, input ready);
  modport sink (input valid, input success, output ready);
endinterface

// ----- hw/rtl/dgr_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, with registered read data.
// ----------------------------------------------------------------------------
module dgr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- hw/rtl/directed_graph_reachability_core.sv -----
// ----------------------------------------------------------------------------
// Directed graph reachability core
// Keeps an adjacency matrix and answers edge updates and path queries.
// ----------------------------------------------------------------------------
// Usage: req carries one item (operation, src_node, dst_node); rsp returns
// one success bit per item, in order. Both are valid/ready channels.
// Add and remove go through the edge state, then the response state: the
// adjacency row of src_node is read from the row RAM, then written back.
// A path query with equal nodes answers with no search. Otherwise a node
// pointer sweeps round the nodes, and each visited node not yet expanded
// costs one RAM row read merged into the visited set; the query ends when
// dst_node is reached or nothing is left to expand. A query takes up to
// NODES sweeps on a long chain that runs against the pointer order;
// typical graphs finish in one or two. The RAM read port, shared by edge
// updates and the search, sets the pace of a query.
// Reset clears all row valid bits at once, so the graph starts empty with no
// clearing pass. The core takes a new item while a result is still waiting;
// a stalled receiver holds the result register, and the next result then
// waits in the core, which accepts no further item until it is passed on.
// ----------------------------------------------------------------------------
`include "directed_graph_reachability_core_defines.svh"

module directed_graph_reachability_core (
  input logic      clk,
  input logic      rst,
  dgr_req_if.sink  req,
  dgr_rsp_if.source rsp
);

  localparam int NODES  = dgr_pkg::NODES;
  localparam int NODE_W = dgr_pkg::NODE_W;

  dgr_pkg::state_t state, state_next;

  logic [dgr_pkg::OP_W-1:0]    op_q, op_q_next;
  logic [dgr_pkg::FIELD_W-1:0] src_q, src_q_next;
  logic [dgr_pkg::FIELD_W-1:0] dst_q, dst_q_next;
  logic                        in_range, in_range_next;
  logic                        result_q, result_q_next;
  logic [NODES-1:0]            visited, visited_next;
  logic [NODES-1:0]            expanded, expanded_next;
  logic [NODE_W-1:0]           ptr, ptr_next;
  logic                        inflight, inflight_next;
  logic [NODES-1:0]            row_valid, row_valid_next;
  logic                        rd_valid;
  logic                        out_valid, out_valid_next;
  logic                        out_success, out_success_next;

  logic                        ram_wr_en;
  logic [NODE_W-1:0]           ram_wr_addr;
  logic [NODES-1:0]            ram_wr_data;
  logic [NODE_W-1:0]           ram_rd_addr;
  logic [NODES-1:0]            ram_rd_data;

  logic [NODES-1:0]            row;
  logic [NODES-1:0]            merged;
  logic [NODES-1:0]            pending;
  logic [NODES-1:0]            dst_mask;
  logic [NODE_W-1:0]           src_idx;
  logic [NODE_W-1:0]           dst_idx;
  logic                        req_in_range;

  // Adjacency rows, one per source node.
  dgr_ram #(
    .WIDTH(NODES),
    .DEPTH(NODES)
  ) u_rows (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  // A row never written since reset reads as empty.
  assign row      = rd_valid ? ram_rd_data : '0;
  assign merged   = inflight ? (visited | row) : visited;
  assign pending  = visited & ~expanded;
  assign src_idx  = NODE_W'(src_q);
  assign dst_idx  = NODE_W'(dst_q);
  assign dst_mask = {{(NODES-1){1'b0}}, 1'b1} << dst_idx;
  assign req_in_range = (32'(req.src_node) < NODES) && (32'(req.dst_node) < NODES);

  assign rsp.valid   = out_valid;
  assign rsp.success = out_success;

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dgr_pkg::ST_IDLE;
      out_valid <= 1'b0;
      row_valid <= '0;
      inflight  <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      row_valid <= row_valid_next;
      inflight  <= inflight_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_q        <= op_q_next;
    src_q       <= src_q_next;
    dst_q       <= dst_q_next;
    in_range    <= in_range_next;
    result_q    <= result_q_next;
    visited     <= visited_next;
    expanded    <= expanded_next;
    ptr         <= ptr_next;
    out_success <= out_success_next;
    rd_valid    <= row_valid[ram_rd_addr];
  end

  // Sequencer: next state, RAM control and result handling.
  always_comb begin
    state_next       = state;
    op_q_next        = op_q;
    src_q_next       = src_q;
    dst_q_next       = dst_q;
    in_range_next    = in_range;
    result_q_next    = result_q;
    visited_next     = visited;
    expanded_next    = expanded;
    ptr_next         = ptr;
    inflight_next    = inflight;
    row_valid_next   = row_valid;
    out_valid_next   = out_valid;
    out_success_next = out_success;
    ram_wr_en        = 1'b0;
    ram_wr_addr      = src_idx;
    ram_wr_data      = row;
    ram_rd_addr      = ptr;
    req.ready        = 1'b0;

    // The receiver takes the current result.
    if (out_valid && rsp.ready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      dgr_pkg::ST_IDLE: begin
        req.ready   = 1'b1;
        ram_rd_addr = NODE_W'(req.src_node);
        if (req.valid) begin
          op_q_next     = req.operation;
          src_q_next    = req.src_node;
          dst_q_next    = req.dst_node;
          in_range_next = req_in_range;
          case (req.operation)
            dgr_pkg::OP_ADD, dgr_pkg::OP_REMOVE: begin
              state_next = dgr_pkg::ST_EDGE;
            end
            dgr_pkg::OP_QUERY: begin
              if (req.src_node == req.dst_node) begin
                result_q_next = 1'b1;
                state_next    = dgr_pkg::ST_RESP;
              end else if (!req_in_range) begin
                result_q_next = 1'b0;
                state_next    = dgr_pkg::ST_RESP;
              end else begin
                visited_next  = {{(NODES-1){1'b0}}, 1'b1} << NODE_W'(req.src_node);
                expanded_next = '0;
                ptr_next      = '0;
                inflight_next = 1'b0;
                state_next    = dgr_pkg::ST_QUERY;
              end
            end
            default: begin
              result_q_next = 1'b0;
              state_next    = dgr_pkg::ST_RESP;
            end
          endcase
        end
      end

      // Read-modify-write of one adjacency row.
      dgr_pkg::ST_EDGE: begin
        state_next = dgr_pkg::ST_RESP;
        case (op_q)
          dgr_pkg::OP_ADD: begin
            result_q_next = 1'b1;
            if (in_range) begin
              ram_wr_en               = 1'b1;
              ram_wr_data             = row | dst_mask;
              row_valid_next[src_idx] = 1'b1;
            end
          end
          dgr_pkg::OP_REMOVE: begin
            result_q_next = in_range && row[dst_idx];
            if (in_range && row[dst_idx]) begin
              ram_wr_en               = 1'b1;
              ram_wr_data             = row & ~dst_mask;
              row_valid_next[src_idx] = 1'b1;
            end
          end
          default: begin
            result_q_next = 1'b0;
          end
        endcase
      end

      // Visited-set expansion, one row read per cycle at most.
      dgr_pkg::ST_QUERY: begin
        visited_next = merged;
        if (merged[dst_idx]) begin
          result_q_next = 1'b1;
          inflight_next = 1'b0;
          state_next    = dgr_pkg::ST_RESP;
        end else if ((pending == '0) && !inflight) begin
          result_q_next = 1'b0;
          inflight_next = 1'b0;
          state_next    = dgr_pkg::ST_RESP;
        end else begin
          inflight_next = pending[ptr];
          if (pending[ptr]) begin
            expanded_next[ptr] = 1'b1;
          end
          ptr_next = ptr + 1'b1;
        end
      end

      // Hand the result to the output register once it is free.
      dgr_pkg::ST_RESP: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next   = 1'b1;
          out_success_next = result_q;
          state_next       = dgr_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = dgr_pkg::ST_IDLE;
      end
    endcase
  end

  // Checks on the sequencer and the search state.
  `DGR_ASSERT_NOW(a_src_visited, state == dgr_pkg::ST_QUERY, visited[src_idx])
  `DGR_ASSERT_NOW(a_expanded_subset, state == dgr_pkg::ST_QUERY, (expanded & ~visited) == '0)
  `DGR_ASSERT_NEXT(a_add_succeeds, (state == dgr_pkg::ST_EDGE) && (op_q == dgr_pkg::OP_ADD), (state == dgr_pkg::ST_RESP) && result_q)
  `DGR_ASSERT_NOW(a_result_from_resp, $rose(out_valid), $past(state == dgr_pkg::ST_RESP))

endmodule

// ----- tb/dgr_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Directed graph reachability checker
// Watches both channels of the core. It keeps its own adjacency matrix,
// predicts the success bit of every accepted request item, and compares each
// accepted result item against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module dgr_checker (
  input  logic clk,
  input  logic rst,
  dgr_req_if   req,
  dgr_rsp_if   rsp,
  output int   errors,
  output int   pending,
  output int   results,
  output int   reached,
  output int   unreached
);

  // One predicted result, tagged with the operation that caused it.
  typedef struct packed {
    logic [dgr_pkg::OP_W-1:0] code;
    logic                     success;
  } outcome_t;

  logic [dgr_pkg::NODES-1:0] adjacency [dgr_pkg::NODES];
  outcome_t                  predicted_outcomes [$];
  outcome_t                  oldest;
  outcome_t                  fresh;

  // Grow the reached set from the source until it stops changing.
  function automatic logic path_exists(input logic [dgr_pkg::NODE_W-1:0] from,
                                       input logic [dgr_pkg::NODE_W-1:0] to);
    logic [dgr_pkg::NODES-1:0] seen;
    logic [dgr_pkg::NODES-1:0] prev;
    if (from == to) begin
      return 1'b1;
    end
    seen       = '0;
    seen[from] = 1'b1;
    do begin
      prev = seen;
      for (int n = 0; n < dgr_pkg::NODES; n++) begin
        if (prev[n]) begin
          seen |= adjacency[n];
        end
      end
    end while (seen != prev);
    return seen[to];
  endfunction

  // Apply one request item to the graph and return its success bit.
  // Every 6-bit index is a valid node while NODES is 64.
  function automatic logic graph_update(input logic [dgr_pkg::OP_W-1:0]   code,
                                        input logic [dgr_pkg::NODE_W-1:0] from,
                                        input logic [dgr_pkg::NODE_W-1:0] to);
    logic hit;
    case (code)
      dgr_pkg::OP_ADD: begin
        adjacency[from][to] = 1'b1;
        return 1'b1;
      end
      dgr_pkg::OP_REMOVE: begin
        hit                 = adjacency[from][to];
        adjacency[from][to] = 1'b0;
        return hit;
      end
      dgr_pkg::OP_QUERY: begin
        return path_exists(from, to);
      end
      default: begin
        return 1'b0;
      end
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < dgr_pkg::NODES; n++) begin
        adjacency[n] = '0;
      end
      predicted_outcomes.delete();
      errors    <= 0;
      pending   <= 0;
      results   <= 0;
      reached   <= 0;
      unreached <= 0;
    end else begin
      // Predict first; a result never belongs to an item accepted in the same cycle.
      if (req.valid && req.ready) begin
        fresh.code    = req.operation;
        fresh.success = graph_update(req.operation, req.src_node, req.dst_node);
        predicted_outcomes.insert(predicted_outcomes.size(), fresh);
      end
      if (rsp.valid && rsp.ready) begin
        results <= results + 1;
        if (predicted_outcomes.size() == 0) begin
          $display("%0t: result item with none expected, expected none, actual success %0b",
                   $time, rsp.success);
          errors <= errors + 1;
        end else begin
          oldest = predicted_outcomes[0];
          predicted_outcomes.delete(0);
          if (rsp.success !== oldest.success) begin
            $display("%0t: success mismatch, expected %0b, actual %0b (operation %0d)",
                     $time, oldest.success, rsp.success, oldest.code);
            errors <= errors + 1;
          end
          if (oldest.code == dgr_pkg::OP_QUERY) begin
            if (oldest.success) begin
              reached <= reached + 1;
            end else begin
              unreached <= unreached + 1;
            end
          end
        end
      end
      pending <= predicted_outcomes.size();
    end
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Directed graph reachability core testbench
// Drives edge updates and path queries through the request channel under
// several idle mixes, with a long receiver hold-off and a full drain, while
// the checker predicts and compares every result item.
// ----------------------------------------------------------------------------
module testbench;

  // The 2-bit operation field also carries the one code with no operation.
  localparam logic [dgr_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 76;
  localparam int TAIL_CYCLES  = 200;
  // Every query on a worst-case chain, every item behind the longest stalls.
  localparam int MAX_CYCLES   = 8000000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dgr_req_if req ();
  dgr_rsp_if rsp ();

  int errors;
  int pending;
  int results;
  int reached;
  int unreached;

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int hold_asked   = 0;
  int hold_taken   = 0;
  int hold_left    = 0;
  int items_sent   = 0;
  int cycles       = 0;
  int cluster_base = 0;

  // Edges added so far, kept so that removes can target existing edges.
  logic [2*dgr_pkg::NODE_W-1:0] live_edges [$];

  directed_graph_reachability_core dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  dgr_checker graph_check (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .errors    (errors),
    .pending   (pending),
    .results   (results),
    .reached   (reached),
    .unreached (unreached)
  );

  always #10 clk = ~clk;

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= MAX_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result receiver: random stalls, or a long hold-off when one is asked for.
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (hold_taken != hold_asked) begin
        hold_taken = hold_asked;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  // Offer one request item after a random gap and wait until it is taken.
  task automatic send_item(input logic [dgr_pkg::OP_W-1:0]   code,
                           input logic [dgr_pkg::NODE_W-1:0] from,
                           input logic [dgr_pkg::NODE_W-1:0] to);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < tx_idle_pct && gap < 30) begin
      gap++;
    end
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid     <= 1'b1;
    req.operation <= code;
    req.src_node  <= from;
    req.dst_node  <= to;
    @(posedge clk);
    while (!req.ready) begin
      @(posedge clk);
    end
    items_sent++;
  endtask

  // Stop offering items until every predicted result has come back.
  task automatic wait_for_results();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
  endtask

  // Mostly nodes from a small moving cluster so that paths form; sometimes any node.
  function automatic logic [dgr_pkg::NODE_W-1:0] pick_node();
    if ($urandom_range(0, 9) == 0) begin
      return dgr_pkg::NODE_W'($urandom_range(0, dgr_pkg::NODES - 1));
    end
    return dgr_pkg::NODE_W'((cluster_base + $urandom_range(0, 11)) % dgr_pkg::NODES);
  endfunction

  task automatic add_edge(input logic [dgr_pkg::NODE_W-1:0] from,
                          input logic [dgr_pkg::NODE_W-1:0] to);
    send_item(dgr_pkg::OP_ADD, from, to);
    live_edges.insert(live_edges.size(), {from, to});
  endtask

  // A chain of edges, then queries along and against it. Descending chains
  // run against the sweep order of the search and need extra passes.
  task automatic build_chain();
    int len;
    int step;
    int at;
    int first;
    int next;
    len  = $urandom_range(2, 8);
    step = $urandom_range(1, 3);
    if ($urandom_range(0, 1) == 1) begin
      step = dgr_pkg::NODES - step;
    end
    at    = pick_node();
    first = at;
    for (int k = 0; k < len; k++) begin
      next = (at + step) % dgr_pkg::NODES;
      add_edge(dgr_pkg::NODE_W'(at), dgr_pkg::NODE_W'(next));
      at = next;
    end
    send_item(dgr_pkg::OP_QUERY, dgr_pkg::NODE_W'(first), dgr_pkg::NODE_W'(at));
    send_item(dgr_pkg::OP_QUERY, dgr_pkg::NODE_W'(at), dgr_pkg::NODE_W'(first));
  endtask

  task automatic random_items(input int count);
    int                           start;
    int                           kind;
    int                           idx;
    logic [dgr_pkg::NODE_W-1:0]   node;
    logic [2*dgr_pkg::NODE_W-1:0] pair;
    start = items_sent;
    while (items_sent - start < count) begin
      if ($urandom_range(0, 39) == 0) begin
        cluster_base = $urandom_range(0, dgr_pkg::NODES - 1);
      end
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
        build_chain();
      end else if (kind < 24 && live_edges.size() > 0) begin
        idx  = $urandom_range(0, live_edges.size() - 1);
        pair = live_edges[idx];
        live_edges.delete(idx);
        send_item(dgr_pkg::OP_REMOVE, pair[2*dgr_pkg::NODE_W-1:dgr_pkg::NODE_W],
                  pair[dgr_pkg::NODE_W-1:0]);
      end else if (kind < 28) begin
        send_item(OP_UNUSED, dgr_pkg::NODE_W'($urandom_range(0, dgr_pkg::NODES - 1)),
                  dgr_pkg::NODE_W'($urandom_range(0, dgr_pkg::NODES - 1)));
      end else if (kind < 31) begin
        node = pick_node();
        send_item(dgr_pkg::OP_QUERY, node, node);
      end else if (kind < 55) begin
        add_edge(pick_node(), pick_node());
      end else if (kind < 62) begin
        send_item(dgr_pkg::OP_REMOVE, pick_node(), pick_node());
      end else begin
        send_item(dgr_pkg::OP_QUERY, pick_node(), pick_node());
      end
    end
  endtask

  // Remove every edge still on record so the next phase starts sparse.
  task automatic tear_down();
    logic [2*dgr_pkg::NODE_W-1:0] pair;
    while (live_edges.size() > 0) begin
      pair = live_edges[0];
      live_edges.delete(0);
      send_item(dgr_pkg::OP_REMOVE, pair[2*dgr_pkg::NODE_W-1:dgr_pkg::NODE_W],
                pair[dgr_pkg::NODE_W-1:0]);
    end
  endtask

  initial begin
    req.valid     = 1'b0;
    req.operation = dgr_pkg::OP_ADD;
    req.src_node  = '0;
    req.dst_node  = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty graph, duplicate edges, self loops, the unused code,
    // removes of absent edges, and a chain against the sweep order.
    send_item(dgr_pkg::OP_QUERY, 6'd5, 6'd5);
    send_item(dgr_pkg::OP_QUERY, 6'd0, 6'd63);
    send_item(dgr_pkg::OP_REMOVE, 6'd0, 6'd63);
    send_item(dgr_pkg::OP_ADD, 6'd0, 6'd63);
    send_item(dgr_pkg::OP_ADD, 6'd0, 6'd63);
    send_item(dgr_pkg::OP_QUERY, 6'd0, 6'd63);
    send_item(dgr_pkg::OP_QUERY, 6'd63, 6'd0);
    send_item(dgr_pkg::OP_ADD, 6'd63, 6'd63);
    send_item(dgr_pkg::OP_QUERY, 6'd63, 6'd0);
    send_item(OP_UNUSED, 6'd63, 6'd0);
    send_item(dgr_pkg::OP_REMOVE, 6'd0, 6'd63);
    send_item(dgr_pkg::OP_REMOVE, 6'd0, 6'd63);
    send_item(dgr_pkg::OP_REMOVE, 6'd63, 6'd63);
    for (int k = 7; k > 0; k--) begin
      add_edge(dgr_pkg::NODE_W'(6 * k), dgr_pkg::NODE_W'(6 * (k - 1)));
    end
    send_item(dgr_pkg::OP_QUERY, 6'd42, 6'd0);
    send_item(dgr_pkg::OP_QUERY, 6'd0, 6'd42);
    wait_for_results();

    // No idling, with a long receiver hold-off while items keep coming.
    random_items(PHASE_ITEMS / 2);
    hold_asked <= hold_asked + 1;
    random_items(12);
    random_items(PHASE_ITEMS / 2);
    tear_down();
    wait_for_results();

    // Sender idle about half the time.
    tx_idle_pct = 49;
    random_items(PHASE_ITEMS);
    tear_down();
    wait_for_results();

    // Receiver stalling about half the time.
    tx_idle_pct  = 0;
    rx_stall_pct = 49;
    random_items(PHASE_ITEMS);
    tear_down();
    wait_for_results();

    // Light idling on both sides.
    tx_idle_pct  = 9;
    rx_stall_pct = 9;
    random_items(PHASE_ITEMS);
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d request items over four idle mixes with a receiver hold-off;",
             items_sent);
    $display("%0d results checked, path queries %0d reachable and %0d unreachable.",
             results, reached, unreached);
    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
